### rtl/dcfr_pkg.sv
package dcfr_pkg;

  localparam logic [7:0] COUNT_MASK = 8'h0f;

  typedef enum logic [1:0] {
    ROLE_CMD1 = 2'd0,
    ROLE_CMD2 = 2'd1,
    ROLE_DATA = 2'd2,
    ROLE_SUM  = 2'd3
  } role_t;

  typedef struct packed {
    logic [7:0] byte_value;
    role_t      byte_role;
    logic [3:0] data_index;
    logic       frame_done;
    logic       checksum_good;
  } result_t;

endpackage

### rtl/dcfr_framer.sv
module dcfr_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output dcfr_pkg::result_t  result
);

  logic [4:0] frame_position_r, frame_position_nxt;
  logic [3:0] payload_length_r, payload_length_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [4:0] data_offset;
  logic       in_data;

  assign data_offset = frame_position_r - 5'd2;
  assign in_data     = (frame_position_r >= 5'd2) && (data_offset < {1'b0, payload_length_r});

  always_comb begin
    frame_position_nxt   = frame_position_r;
    payload_length_nxt   = payload_length_r;
    running_sum_nxt      = running_sum_r;
    result.byte_value    = rx_byte;
    result.byte_role     = dcfr_pkg::ROLE_SUM;
    result.data_index    = 4'd0;
    result.frame_done    = 1'b0;
    result.checksum_good = 1'b0;
    priority if (frame_position_r == 5'd0) begin
      result.byte_role   = dcfr_pkg::ROLE_CMD1;
      payload_length_nxt = rx_byte[3:0] & dcfr_pkg::COUNT_MASK[3:0];
      running_sum_nxt    = rx_byte;
      frame_position_nxt = 5'd1;
    end else if (frame_position_r == 5'd1) begin
      result.byte_role   = dcfr_pkg::ROLE_CMD2;
      running_sum_nxt    = running_sum_r + rx_byte;
      frame_position_nxt = 5'd2;
    end else if (in_data) begin
      result.byte_role   = dcfr_pkg::ROLE_DATA;
      result.data_index  = data_offset[3:0];
      running_sum_nxt    = running_sum_r + rx_byte;
      frame_position_nxt = frame_position_r + 5'd1;
    end else begin
      result.byte_role     = dcfr_pkg::ROLE_SUM;
      result.frame_done    = 1'b1;
      result.checksum_good = (running_sum_r == rx_byte);
      frame_position_nxt   = 5'd0;
      running_sum_nxt      = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_position_r <= 5'd0;
      payload_length_r <= 4'd0;
      running_sum_r    <= 8'd0;
    end else if (accept) begin
      frame_position_r <= frame_position_nxt;
      payload_length_r <= payload_length_nxt;
      running_sum_r    <= running_sum_nxt;
    end
  end

`ifndef SYNTHESIS
  a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_position_r <= ({1'b0, payload_length_r} + 5'd2))
    else $error("frame position past end of frame");
  a_sum_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && result.frame_done |=> frame_position_r == 5'd0 && running_sum_r == 8'd0)
    else $error("frame did not restart after checksum byte");
`endif

endmodule

### rtl/dcfr_out_buf.sv
module dcfr_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcfr_pkg::result_t  in_result,
  output logic               out_valid,
  input  logic               out_stall,
  output dcfr_pkg::result_t  out_result
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  dcfr_pkg::result_t out_data_r, out_data_nxt;
  dcfr_pkg::result_t skid_data_r, skid_data_nxt;
  logic              take_in;
  logic              out_free;

  assign in_stall   = skid_valid_r;
  assign take_in    = in_valid && !skid_valid_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_result = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = in_result;
        out_valid_nxt = take_in;
      end
    end else if (take_in) begin
      skid_data_nxt  = in_result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output is empty");
`endif

endmodule

### rtl/deck_control_frame_receiver.sv
// An accepted byte updates the frame state in the same cycle as accept; its result is
// registered in the output buffer. Throughput: one byte per cycle while in_stall is low.
// A two-entry output buffer keeps accepting while one result waits on a stalled output.
// Reset (rst_n low, synchronous): frame position, data count and running sum clear to zero,
// and both output buffer entries are emptied.
module deck_control_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_value,
  output logic [1:0] out_byte_role,
  output logic [3:0] out_data_index,
  output logic       out_frame_done,
  output logic       out_checksum_good
);

  logic              accept;
  dcfr_pkg::result_t frame_result;
  dcfr_pkg::result_t buf_result;

  assign accept = in_valid && !in_stall;

  dcfr_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .result  (frame_result)
  );

  dcfr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_result  (frame_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (buf_result)
  );

  assign out_byte_value    = buf_result.byte_value;
  assign out_byte_role     = buf_result.byte_role;
  assign out_data_index    = buf_result.data_index;
  assign out_frame_done    = buf_result.frame_done;
  assign out_checksum_good = buf_result.checksum_good;

`ifndef SYNTHESIS
  a_good_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_good |-> out_frame_done)
    else $error("checksum_good without frame_done");
  a_done_on_sum_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_done == (out_byte_role == dcfr_pkg::ROLE_SUM))
    else $error("frame_done does not match checksum role");
  a_index_zero_off_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_role != dcfr_pkg::ROLE_DATA |-> out_data_index == 4'd0)
    else $error("nonzero data index on a non-data byte");
`endif

endmodule

### dv/tb_deck_control_frame_receiver.sv
`timescale 1ns / 100ps

module tb_deck_control_frame_receiver;

  class frame_scoreboard;
    logic [4:0]          frame_pos;
    logic [3:0]          data_count;
    logic [7:0]          byte_sum;
    dcfr_pkg::result_t   awaited[$];
    int                  errors;

    function new();
      frame_pos  = '0;
      data_count = '0;
      byte_sum   = '0;
      errors     = 0;
    endfunction

    function void note_request(logic [7:0] rx);
      dcfr_pkg::result_t r;
      logic [7:0]        masked;
      logic [4:0]        offset;
      r.byte_value    = rx;
      r.byte_role     = dcfr_pkg::ROLE_CMD1;
      r.data_index    = '0;
      r.frame_done    = 1'b0;
      r.checksum_good = 1'b0;
      offset          = frame_pos - 5'd2;
      if (frame_pos == 5'd0) begin
        masked     = rx & dcfr_pkg::COUNT_MASK;
        data_count = masked[3:0];
        byte_sum   = rx;
        frame_pos  = 5'd1;
      end else if (frame_pos == 5'd1) begin
        r.byte_role = dcfr_pkg::ROLE_CMD2;
        byte_sum    = byte_sum + rx;
        frame_pos   = 5'd2;
      end else if (int'(offset) < int'(data_count)) begin
        r.byte_role  = dcfr_pkg::ROLE_DATA;
        r.data_index = offset[3:0];
        byte_sum     = byte_sum + rx;
        frame_pos    = frame_pos + 5'd1;
      end else begin
        r.byte_role     = dcfr_pkg::ROLE_SUM;
        r.frame_done    = 1'b1;
        r.checksum_good = (byte_sum == rx);
        frame_pos       = '0;
        byte_sum        = '0;
      end
      awaited.push_back(r);
    endfunction

    function void check_result(dcfr_pkg::result_t got);
      dcfr_pkg::result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result value=%0d role=%0d", $time, got.byte_value,
                 got.byte_role);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.byte_value !== want.byte_value) begin
        $display("%0t: byte_value expected %0d actual %0d", $time, want.byte_value,
                 got.byte_value);
        errors++;
      end
      if (got.byte_role !== want.byte_role) begin
        $display("%0t: byte_role expected %0d actual %0d", $time, want.byte_role,
                 got.byte_role);
        errors++;
      end
      if (got.data_index !== want.data_index) begin
        $display("%0t: data_index expected %0d actual %0d", $time, want.data_index,
                 got.data_index);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $display("%0t: frame_done expected %0d actual %0d", $time, want.frame_done,
                 got.frame_done);
        errors++;
      end
      if (got.checksum_good !== want.checksum_good) begin
        $display("%0t: checksum_good expected %0d actual %0d", $time, want.checksum_good,
                 got.checksum_good);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       quiet      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte_value;
  logic [1:0] out_byte_role;
  logic [3:0] out_data_index;
  logic       out_frame_done;
  logic       out_checksum_good;

  logic [7:0] byte_stream[$];
  frame_scoreboard sb = new();

  deck_control_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_value   (out_byte_value),
    .out_byte_role    (out_byte_role),
    .out_data_index   (out_data_index),
    .out_frame_done   (out_frame_done),
    .out_checksum_good(out_checksum_good)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("tb_deck_control_frame_receiver NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    dcfr_pkg::result_t got;
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_rx_byte);
    end
    if (rst_n && out_valid && !out_stall) begin
      got.byte_value    = out_byte_value;
      got.byte_role     = dcfr_pkg::role_t'(out_byte_role);
      got.data_index    = out_data_index;
      got.frame_done    = out_frame_done;
      got.checksum_good = out_checksum_good;
      sb.check_result(got);
    end
  end

  task automatic add_frame(input logic [7:0] cmd1, input logic [7:0] cmd2,
                           input logic [7:0] payload[$], input bit corrupt);
    logic [7:0] sum;
    sum = cmd1 + cmd2;
    byte_stream.push_back(cmd1);
    byte_stream.push_back(cmd2);
    foreach (payload[i]) begin
      byte_stream.push_back(payload[i]);
      sum = sum + payload[i];
    end
    if (corrupt) begin
      sum = sum + 8'($urandom_range(255, 1));
    end
    byte_stream.push_back(sum);
  endtask

  task automatic send_stream();
    int idx;
    idx = 0;
    while (1) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        idx++;
      end
      quiet <= (idx >= 300 && idx < 520);
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (idx < byte_stream.size() &&
                   ((idx >= 300 && idx < 520) || $urandom_range(99) >= 12)) begin
        in_valid   <= 1'b1;
        in_rx_byte <= byte_stream[idx];
      end else begin
        in_valid <= 1'b0;
      end
      if (idx >= byte_stream.size()) begin
        break;
      end
    end
  endtask

  initial begin
    logic [7:0] payload[$];
    logic [3:0] count;
    int         guard;

    add_frame(8'h00, 8'h00, payload, 1'b0);
    add_frame(8'hf0, 8'hff, payload, 1'b1);
    payload = '{8'hff, 8'h00};
    add_frame(8'h02, 8'h7f, payload, 1'b0);
    payload = '{8'hff};
    add_frame(8'h01, 8'h80, payload, 1'b0);
    payload = '{8'haa, 8'h01, 8'hfe};
    add_frame(8'ha3, 8'h55, payload, 1'b1);

    while (byte_stream.size() < 1050) begin
      if ($urandom_range(99) < 88) begin
        payload.delete();
        count = 4'($urandom_range(15));
        for (int i = 0; i < count; i++) begin
          payload.push_back(8'($urandom_range(255)));
        end
        add_frame({4'($urandom_range(15)), count}, 8'($urandom_range(255)), payload,
                  $urandom_range(3) == 0);
      end else begin
        repeat ($urandom_range(6, 1)) byte_stream.push_back(8'($urandom_range(255)));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_stream();

    guard = 0;
    while (sb.pending() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_deck_control_frame_receiver OK");
    end else begin
      $display("tb_deck_control_frame_receiver NOT OK");
    end
    $finish;
  end

endmodule

### deck_control_frame_receiver.f
rtl/dcfr_pkg.sv
rtl/dcfr_framer.sv
rtl/dcfr_out_buf.sv
rtl/deck_control_frame_receiver.sv
dv/tb_deck_control_frame_receiver.sv
